/* sv/first_fit_block_allocator_macros.svh */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_macros
// assertion helpers shared by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// condition holds at every edge out of reset
`define FFBA_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FFBA_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// codes and helpers of the first-fit block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NULL    = 3'd1;
    localparam logic [2:0] ST_ARENA   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    localparam logic [1:0] REG_HEAP_BASE  = 2'd0;
    localparam logic [1:0] REG_INIT_BYTES = 2'd1;
    localparam logic [1:0] REG_HEAP_LIMIT = 2'd2;

    localparam logic [31:0] RST_HEAP_BASE  = 32'h0040_0000;
    localparam logic [31:0] RST_INIT_BYTES = 32'h0010_0000;
    localparam logic [31:0] RST_HEAP_LIMIT = 32'hFFFF_FFFF;

    typedef enum logic [9:0] {
        S_INIT  = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_START = 10'b00_0000_0100,
        S_CHK   = 10'b00_0000_1000,
        S_WR2   = 10'b00_0001_0000,
        S_GROW1 = 10'b00_0010_0000,
        S_GROW2 = 10'b00_0100_0000,
        S_FNX   = 10'b00_1000_0000,
        S_FPRV  = 10'b01_0000_0000,
        S_RESP  = 10'b10_0000_0000
    } t_state;

    function automatic logic [31:0] sat32(input logic [33:0] v);
        return (v[33:32] != 2'b00) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

`default_nettype wire

/* sv/first_fit_block_allocator.sv */
// a zero request or a null free skips the walk and goes straight to the result beat,
// otherwise the command walks the block table from the head
// the block takes one command at a time
// the walk reads one table entry per cycle through the single read port of the block ram
// reset and writes to heap_base or initial_bytes pass through S_INIT to rebuild block 0
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit heap block table with split, grow and merge
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 12,
    parameter int PAGE_BYTES   = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // apb
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic      [31:0] o_prdata,
    output logic             o_pready,
    // command beats
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // request_bytes, release_address
    input  wire logic [0:0]  i_s_tuser,   // command
    // result beats
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [39:0] o_m_tdata    // payload_address, status, zero pad
);

`include "first_fit_block_allocator_macros.svh"

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int NW = $clog2(MAX_BLOCKS + 1);
    localparam logic [NW-1:0] NIL   = NW'(MAX_BLOCKS);
    localparam logic [31:0]   HDR   = 32'(HEADER_BYTES);
    localparam logic [33:0]   HDR34 = 34'(HEADER_BYTES);
    localparam logic [33:0]   PGM   = 34'(PAGE_BYTES - 1);

    typedef struct packed {
        logic [31:0]   start;
        logic [31:0]   size;
        logic          free;
        logic [NW-1:0] nxt;
    } t_entry;

    localparam int EW = $bits(t_entry);

    t_state          r_state;
    logic [31:0]     r_base, r_init_bytes, r_limit;
    logic            r_cmd;
    logic [31:0]     r_req, r_rel;
    logic [NW-1:0]   r_cur, r_hops, r_prev;
    logic            r_prev_vld;
    t_entry          r_prev_d, r_cur_d, r_w2_d;
    logic [IW-1:0]   r_w2_addr;
    logic [33:0]     r_new_end;
    logic [31:0]     r_res_addr;
    logic [2:0]      r_res_st;
    logic [MAX_BLOCKS-1:0] r_in_use;
    logic [IW-1:0]   r_head;
    logic [31:0]     r_heap_end;
    logic            r_ovld;
    logic [31:0]     r_oaddr;
    logic [2:0]      r_ost;

    logic            w_we;
    logic [IW-1:0]   w_waddr, w_raddr;
    t_entry          w_wdata, w_rd, w_cmerge, w_pmerge;
    logic [EW-1:0]   w_rdata;
    logic            w_cfg_we, w_in_acc, w_out_acc, w_reinit;
    logic [1:0]      w_cfg_idx;
    logic [IW-1:0]   w_fs;
    logic            w_fs_ok;
    logic            w_hit, w_split, w_step_ok, w_nx_merge, w_pv_merge, w_grow_bad;
    logic [NW-1:0]   w_hops_inc;
    logic [33:0]     w_grow_sum;

    function automatic logic vld(input logic [NW-1:0] s);
        return (s < NIL) && r_in_use[s[IW-1:0]];
    endfunction

    assign o_pready   = 1'b1;
    assign w_cfg_idx  = i_paddr[3:2];
    assign w_cfg_we   = i_psel & i_penable & i_pwrite;
    assign w_reinit   = w_cfg_we &&
                        (w_cfg_idx == REG_HEAP_BASE || w_cfg_idx == REG_INIT_BYTES);
    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_tvalid & o_s_tready;
    assign w_out_acc  = r_ovld & i_m_tready;
    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {5'b0, r_ost, r_oaddr};

    always_comb begin
        unique case (w_cfg_idx)
            REG_HEAP_BASE:  o_prdata = r_base;
            REG_INIT_BYTES: o_prdata = r_init_bytes;
            REG_HEAP_LIMIT: o_prdata = r_limit;
            default:        o_prdata = 32'b0;
        endcase
    end

    always_comb begin
        w_fs    = '0;
        w_fs_ok = 1'b0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                w_fs    = IW'(i);
                w_fs_ok = 1'b1;
            end
        end
    end

    assign w_rd       = t_entry'(w_rdata);
    assign w_hops_inc = r_hops + NW'(1);
    assign w_step_ok  = vld(w_rd.nxt) && (w_hops_inc < NIL);
    assign w_hit      = (r_cmd == CMD_ALLOC) ? (w_rd.free && (w_rd.size >= r_req))
                                             : ((w_rd.start + HDR) == r_rel);
    assign w_split    = ({1'b0, w_rd.size} > ({1'b0, r_req} + 33'(HEADER_BYTES))) && w_fs_ok;
    assign w_grow_sum = {2'b0, r_heap_end} + {2'b0, r_req} + HDR34;
    assign w_grow_bad = (r_new_end[33:32] != 2'b00) || (r_new_end[31:0] > r_limit);

    assign w_nx_merge = vld(r_cur_d.nxt) && w_rd.free;
    always_comb begin
        w_cmerge      = r_cur_d;
        w_cmerge.free = 1'b1;
        if (w_nx_merge) begin
            w_cmerge.size = sat32({2'b0, r_cur_d.size} + HDR34 + {2'b0, w_rd.size});
            w_cmerge.nxt  = w_rd.nxt;
        end
    end

    assign w_pv_merge = r_prev_vld && r_prev_d.free;
    always_comb begin
        w_pmerge      = r_prev_d;
        w_pmerge.size = sat32({2'b0, r_prev_d.size} + HDR34 + {2'b0, r_cur_d.size});
        w_pmerge.nxt  = r_cur_d.nxt;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cur[IW-1:0];
        w_wdata = w_rd;
        w_raddr = r_cur[IW-1:0];
        unique case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '{start: r_base,
                            size: (r_init_bytes >= HDR) ? r_init_bytes - HDR : 32'b0,
                            free: 1'b1, nxt: NIL};
            end
            S_START: begin
                w_raddr = r_head;
            end
            S_CHK: begin
                w_raddr = w_rd.nxt[IW-1:0];
                if (w_hit && r_cmd == CMD_ALLOC) begin
                    w_we = 1'b1;
                    if (w_split) begin
                        w_wdata = '{start: w_rd.start, size: r_req, free: 1'b0,
                                    nxt: NW'(w_fs)};
                    end else begin
                        w_wdata      = w_rd;
                        w_wdata.free = 1'b0;
                    end
                end
            end
            S_WR2: begin
                w_we    = 1'b1;
                w_waddr = r_w2_addr;
                w_wdata = r_w2_d;
            end
            S_GROW2: begin
                w_we    = !w_grow_bad && w_fs_ok;
                w_waddr = w_fs;
                w_wdata = '{start: r_heap_end, size: r_req, free: 1'b0, nxt: NIL};
            end
            S_FNX: begin
                w_we    = 1'b1;
                w_wdata = w_cmerge;
            end
            S_FPRV: begin
                w_we    = w_pv_merge;
                w_waddr = r_prev[IW-1:0];
                w_wdata = w_pmerge;
            end
            default: begin
            end
        endcase
    end

    ffba_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_base       <= RST_HEAP_BASE;
            r_init_bytes <= RST_INIT_BYTES;
            r_limit      <= RST_HEAP_LIMIT;
            r_in_use     <= MAX_BLOCKS'(1);
            r_head       <= '0;
            r_heap_end   <= 32'b0;
            r_ovld       <= 1'b0;
            r_prev_vld   <= 1'b0;
        end else begin
            if (w_out_acc && r_state != S_RESP) begin
                r_ovld <= 1'b0;
            end
            if (w_cfg_we) begin
                unique case (w_cfg_idx)
                    REG_HEAP_BASE:  r_base       <= i_pwdata;
                    REG_INIT_BYTES: r_init_bytes <= i_pwdata;
                    REG_HEAP_LIMIT: r_limit      <= i_pwdata;
                    default: begin
                    end
                endcase
            end
            if (w_reinit) begin
                r_state <= S_INIT;
            end else begin
                unique case (r_state)
                    S_INIT: begin
                        r_in_use   <= MAX_BLOCKS'(1);
                        r_head     <= '0;
                        r_heap_end <= sat32({2'b0, r_base} + {2'b0, r_init_bytes});
                        r_state    <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (w_in_acc) begin
                            r_cmd      <= i_s_tuser[0];
                            r_req      <= i_s_tdata[31:0];
                            r_rel      <= i_s_tdata[63:32];
                            r_cur      <= NW'(r_head);
                            r_hops     <= '0;
                            r_prev_vld <= 1'b0;
                            r_res_addr <= 32'b0;
                            if ((i_s_tuser[0] == CMD_ALLOC && i_s_tdata[31:0] == 32'b0) ||
                                (i_s_tuser[0] == CMD_FREE && i_s_tdata[63:32] == 32'b0)) begin
                                r_res_st <= ST_NULL;
                                r_state  <= S_RESP;
                            end else begin
                                r_state <= S_START;
                            end
                        end
                    end
                    S_START: begin
                        if (vld(r_cur)) begin
                            r_state <= S_CHK;
                        end else if (r_cmd == CMD_ALLOC) begin
                            r_state <= S_GROW1;
                        end else begin
                            r_res_st <= ST_UNKNOWN;
                            r_state  <= S_RESP;
                        end
                    end
                    S_CHK: begin
                        if (w_hit) begin
                            if (r_cmd == CMD_ALLOC) begin
                                r_res_addr <= w_rd.start + HDR;
                                r_res_st   <= ST_OK;
                                if (w_split) begin
                                    r_in_use[w_fs] <= 1'b1;
                                    r_w2_addr      <= w_fs;
                                    r_w2_d         <= '{start: w_rd.start + HDR + r_req,
                                                        size: w_rd.size - r_req - HDR,
                                                        free: 1'b1, nxt: w_rd.nxt};
                                    r_state        <= S_WR2;
                                end else begin
                                    r_state <= S_RESP;
                                end
                            end else begin
                                r_cur_d <= w_rd;
                                r_state <= S_FNX;
                            end
                        end else begin
                            r_prev     <= r_cur;
                            r_prev_d   <= w_rd;
                            r_prev_vld <= 1'b1;
                            r_hops     <= w_hops_inc;
                            r_cur      <= w_rd.nxt;
                            if (!w_step_ok) begin
                                if (r_cmd == CMD_ALLOC) begin
                                    r_state <= S_GROW1;
                                end else begin
                                    r_res_st <= ST_UNKNOWN;
                                    r_state  <= S_RESP;
                                end
                            end
                        end
                    end
                    S_WR2: begin
                        r_state <= S_RESP;
                    end
                    S_GROW1: begin
                        r_new_end <= (w_grow_sum + PGM) & ~PGM;
                        r_state   <= S_GROW2;
                    end
                    S_GROW2: begin
                        if (w_grow_bad) begin
                            r_res_st <= ST_ARENA;
                            r_state  <= S_RESP;
                        end else if (!w_fs_ok) begin
                            r_res_st <= ST_FULL;
                            r_state  <= S_RESP;
                        end else begin
                            r_in_use[w_fs] <= 1'b1;
                            r_res_addr     <= r_heap_end + HDR;
                            r_res_st       <= ST_OK;
                            r_heap_end     <= r_new_end[31:0];
                            if (r_prev_vld) begin
                                r_w2_addr <= r_prev[IW-1:0];
                                r_w2_d    <= '{start: r_prev_d.start, size: r_prev_d.size,
                                               free: r_prev_d.free, nxt: NW'(w_fs)};
                                r_state   <= S_WR2;
                            end else begin
                                r_head  <= w_fs;
                                r_state <= S_RESP;
                            end
                        end
                    end
                    S_FNX: begin
                        r_cur_d <= w_cmerge;
                        if (w_nx_merge) begin
                            r_in_use[r_cur_d.nxt[IW-1:0]] <= 1'b0;
                        end
                        r_state <= S_FPRV;
                    end
                    S_FPRV: begin
                        if (w_pv_merge) begin
                            r_in_use[r_cur[IW-1:0]] <= 1'b0;
                        end
                        r_res_st <= ST_OK;
                        r_state  <= S_RESP;
                    end
                    S_RESP: begin
                        if (!r_ovld || i_m_tready) begin
                            r_ovld  <= 1'b1;
                            r_oaddr <= r_res_addr;
                            r_ost   <= r_res_st;
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_INIT;
                endcase
            end
        end
    end

    `FFBA_CHECK(a_head_in_use, r_in_use[r_head], "head slot not in use")
    `FFBA_CHECK(a_table_nonempty, r_in_use != '0, "block table empty")
    `FFBA_IMPLY(a_accept_busy, w_in_acc, !o_s_tready, "ready right after a command beat")

endmodule

`default_nettype wire

/* sv/ffba_ram.sv */
// ----------------------------------------------------------------------------
// ffba_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the first-fit block allocator: a directed table
// followed by random allocate and free traffic over several arena settings,
// results matched to typed rows or a behavioral model of the block table
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import ffba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBLK    = 64;
    localparam int HDR     = 12;
    localparam int PAGE    = 4096;
    localparam int NIL     = NBLK;
    localparam int LIMIT   = 600000;
    localparam int N_RAND  = 100;

    typedef struct packed {
        logic [31:0] addr;
        logic [2:0]  st;
    } t_result;

    typedef struct {
        logic        cmd;
        logic [31:0] req;
        logic [31:0] rel;
        bit          typed;
        logic [31:0] exp_addr;
        logic [2:0]  exp_st;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [3:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic [0:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;

    first_fit_block_allocator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // model of the block table
    logic [31:0] cfg_base, cfg_init, cfg_limit;
    logic [31:0] blk_start [NBLK];
    logic [31:0] blk_size  [NBLK];
    bit          blk_free  [NBLK];
    int          blk_next  [NBLK];
    bit          blk_used  [NBLK];
    int          head_blk;
    logic [31:0] arena_end;

    t_result     pending_q [$];
    logic [31:0] granted_q [$];
    int          n_err, n_checked, n_alloc, n_free, n_phase, cycles;
    bit          burst;

    function automatic logic [31:0] clip32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic bit live(int s);
        return s < NIL && blk_used[s];
    endfunction

    function automatic int spare_blk();
        for (int i = 0; i < NBLK; i++)
            if (!blk_used[i]) return i;
        return NIL;
    endfunction

    function automatic void rebuild_arena();
        for (int i = 0; i < NBLK; i++) begin
            blk_start[i] = '0;
            blk_size[i]  = '0;
            blk_free[i]  = 0;
            blk_used[i]  = 0;
            blk_next[i]  = NIL;
        end
        blk_used[0]  = 1;
        blk_start[0] = cfg_base;
        blk_size[0]  = (cfg_init >= HDR) ? cfg_init - HDR : '0;
        blk_free[0]  = 1;
        head_blk     = 0;
        arena_end    = clip32({32'd0, cfg_base} + {32'd0, cfg_init});
        granted_q.delete();
    endfunction

    function automatic t_result alloc_blk(logic [31:0] req);
        t_result     r;
        int          cur, last, hops, s;
        logic [63:0] grown;
        r = '{addr: '0, st: ST_OK};
        cur = head_blk;
        last = NIL;
        hops = 0;
        if (req == 0) begin
            r.st = ST_NULL;
            return r;
        end
        while (live(cur) && hops < NIL) begin
            if (blk_free[cur] && blk_size[cur] >= req) break;
            last = cur;
            cur = blk_next[cur];
            hops++;
        end
        if (live(cur) && hops < NIL) begin
            blk_free[cur] = 0;
            if ({32'd0, blk_size[cur]} > {32'd0, req} + HDR) begin
                s = spare_blk();
                if (s != NIL) begin
                    blk_used[s]  = 1;
                    blk_start[s] = blk_start[cur] + HDR + req;
                    blk_size[s]  = blk_size[cur] - req - HDR;
                    blk_free[s]  = 1;
                    blk_next[s]  = blk_next[cur];
                    blk_size[cur] = req;
                    blk_next[cur] = s;
                end
            end
            r.addr = blk_start[cur] + HDR;
            return r;
        end
        grown = {32'd0, arena_end} + {32'd0, req} + HDR;
        if (grown % PAGE != 0) grown = grown - (grown % PAGE) + PAGE;
        if (grown > 64'hFFFF_FFFF || grown > {32'd0, cfg_limit}) begin
            r.st = ST_ARENA;
            return r;
        end
        s = spare_blk();
        if (s == NIL) begin
            r.st = ST_FULL;
            return r;
        end
        blk_used[s]  = 1;
        blk_start[s] = arena_end;
        blk_size[s]  = req;
        blk_free[s]  = 0;
        blk_next[s]  = NIL;
        if (live(last)) blk_next[last] = s;
        else head_blk = s;
        r.addr = arena_end + HDR;
        arena_end = grown[31:0];
        return r;
    endfunction

    function automatic t_result free_blk(logic [31:0] rel);
        t_result r;
        int      cur, prev, hops, nx;
        r = '{addr: '0, st: ST_OK};
        cur = head_blk;
        prev = NIL;
        hops = 0;
        if (rel == 0) begin
            r.st = ST_NULL;
            return r;
        end
        while (live(cur) && hops < NIL) begin
            if (blk_start[cur] + HDR == rel) break;
            prev = cur;
            cur = blk_next[cur];
            hops++;
        end
        if (!live(cur) || hops >= NIL) begin
            r.st = ST_UNKNOWN;
            return r;
        end
        blk_free[cur] = 1;
        nx = blk_next[cur];
        if (live(nx) && blk_free[nx]) begin
            blk_size[cur] = clip32({32'd0, blk_size[cur]} + HDR + {32'd0, blk_size[nx]});
            blk_next[cur] = blk_next[nx];
            blk_used[nx]  = 0;
        end
        if (live(prev) && blk_free[prev]) begin
            blk_size[prev] = clip32({32'd0, blk_size[prev]} + HDR + {32'd0, blk_size[cur]});
            blk_next[prev] = blk_next[cur];
            blk_used[cur]  = 0;
        end
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // result beat checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{addr: o_m_tdata[31:0], st: o_m_tdata[34:32]};
            if (pending_q.size() == 0) begin
                if (n_err < 10) $display("unexpected result beat addr=%h st=%0d",
                                         got.addr, got.st);
                n_err++;
            end else begin
                want = pending_q.pop_front();
                n_checked++;
                if (got.addr !== want.addr || got.st !== want.st) begin
                    if (n_err < 10)
                        $display("mismatch: expected addr=%h st=%0d, got addr=%h st=%0d",
                                 want.addr, want.st, got.addr, got.st);
                    n_err++;
                end
            end
        end
    end

    // result side back-pressure
    initial begin
        int n;
        i_m_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = burst ? 0 : $urandom_range(0, 9);
            if (n > 0) begin
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        case (idx)
            REG_HEAP_BASE: begin
                cfg_base = val;
                rebuild_arena();
            end
            REG_INIT_BYTES: begin
                cfg_init = val;
                rebuild_arena();
            end
            default: cfg_limit = val;
        endcase
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_arena(logic [31:0] base, logic [31:0] init, logic [31:0] lim);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        reg_write(REG_HEAP_BASE, base);
        reg_write(REG_INIT_BYTES, init);
        reg_write(REG_HEAP_LIMIT, lim);
        n_phase++;
    endtask

    task automatic send_cmd(logic cmd, logic [31:0] req, logic [31:0] rel,
                            bit typed = 0, t_result typed_res = '0);
        int      gap;
        t_result r;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {rel, req};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        if (cmd == CMD_ALLOC) begin
            r = alloc_blk(req);
            n_alloc++;
            if (r.st == ST_OK) granted_q.push_back(r.addr);
        end else begin
            r = free_blk(rel);
            n_free++;
        end
        pending_q.push_back(typed ? typed_res : r);
    endtask

    task automatic random_cmd();
        int          k, j;
        logic [31:0] req, rel;
        k = $urandom_range(0, 99);
        if (k < 55) begin
            j = $urandom_range(0, 99);
            if (j < 70)      req = $urandom_range(1, 3000);
            else if (j < 85) req = $urandom_range(3001, 40000);
            else if (j < 95) req = $urandom;
            else             req = '0;
            send_cmd(CMD_ALLOC, req, $urandom);
        end else begin
            j = $urandom_range(0, 99);
            if (j < 75 && granted_q.size() > 0) begin
                k = $urandom_range(0, granted_q.size() - 1);
                rel = granted_q[k];
                if ($urandom_range(0, 2) != 0) granted_q.delete(k);
            end else if (j < 85) begin
                rel = '0;
            end else if (j < 95 || granted_q.size() == 0) begin
                rel = $urandom;
            end else begin
                rel = granted_q[0] + 1;
            end
            send_cmd(CMD_FREE, $urandom, rel);
        end
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            random_cmd();
        end
        i_s_tvalid <= 1'b0;
        burst = 0;
    endtask

    t_row dir_tbl [] = '{
        '{CMD_ALLOC, 32'd0,          32'h1,        1, 32'h0,        ST_NULL},
        '{CMD_ALLOC, 32'd100,        32'h0,        1, 32'h0040_000C, ST_OK},
        '{CMD_ALLOC, 32'hFFFF_FFFF,  32'h0,        1, 32'h0,        ST_ARENA},
        '{CMD_FREE,  32'h0,          32'h0,        1, 32'h0,        ST_NULL},
        '{CMD_FREE,  32'hFFFF_FFFF,  32'h1,        1, 32'h0,        ST_UNKNOWN},
        '{CMD_FREE,  32'h0,          32'hFFFF_FFFF, 1, 32'h0,       ST_UNKNOWN},
        '{CMD_FREE,  32'h0,          32'h0040_000C, 1, 32'h0,       ST_OK},
        '{CMD_ALLOC, 32'h000F_FFF4,  32'h0,        1, 32'h0040_000C, ST_OK},
        '{CMD_ALLOC, 32'd1,          32'h0,        1, 32'h0050_000C, ST_OK},
        '{CMD_FREE,  32'h0,          32'h0050_000C, 1, 32'h0,       ST_OK},
        '{CMD_FREE,  32'h0,          32'h0050_000C, 1, 32'h0,       ST_OK},
        '{CMD_ALLOC, 32'h000F_FFF5,  32'h0,        0, 32'h0,        ST_OK},
        '{CMD_ALLOC, 32'd4096,       32'h0,        0, 32'h0,        ST_OK},
        '{CMD_ALLOC, 32'h8000_0000,  32'h0,        0, 32'h0,        ST_OK},
        '{CMD_FREE,  32'h0,          32'h0040_000C, 0, 32'h0,       ST_OK},
        '{CMD_ALLOC, 32'd50,         32'h0,        0, 32'h0,        ST_OK},
        '{CMD_ALLOC, 32'd50,         32'h0,        0, 32'h0,        ST_OK}
    };

    initial begin
        cycles     = 0;
        n_err      = 0;
        n_checked  = 0;
        n_alloc    = 0;
        n_free     = 0;
        n_phase    = 1;
        burst      = 0;
        i_rst_n    = 1'b0;
        i_psel     = 1'b0;
        i_penable  = 1'b0;
        i_pwrite   = 1'b0;
        i_paddr    = '0;
        i_pwdata   = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        cfg_base   = RST_HEAP_BASE;
        cfg_init   = RST_INIT_BYTES;
        cfg_limit  = RST_HEAP_LIMIT;
        rebuild_arena();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        foreach (dir_tbl[i])
            send_cmd(dir_tbl[i].cmd, dir_tbl[i].req, dir_tbl[i].rel, dir_tbl[i].typed,
                     '{addr: dir_tbl[i].exp_addr, st: dir_tbl[i].exp_st});
        random_phase(N_RAND);

        set_arena(RST_HEAP_BASE, RST_INIT_BYTES, 32'h0052_0000);
        random_phase(N_RAND);
        set_arena(32'h0, 32'd4096, 32'hFFFF_FFFF);
        random_phase(N_RAND);
        set_arena(32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(N_RAND);
        set_arena(32'h0000_1000, 32'd5, 32'h0010_0000);
        random_phase(N_RAND);
        set_arena(32'h0020_0000, 32'd8192, 32'h0);
        random_phase(N_RAND);
        set_arena(32'h1000_0000, 32'h0000_2000, 32'hFFFF_FFFF);
        random_phase(N_RAND);

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (pending_q.size() != 0) n_err++;
        $display("%0d allocate and %0d free commands over %0d arena settings",
                 n_alloc, n_free, n_phase);
        $display("%0d results checked, %0d mismatches", n_checked, n_err);
        if (n_err == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+sv
sv/ffba_pkg.sv
sv/ffba_ram.sv
sv/first_fit_block_allocator.sv
sim/tb_top.sv
